// ===== rtl/nalbp_pkg.sv =====
// ----------------------------------------------------------------------------
// nalbp_pkg
// shared types and constants of the three-scale neighbor-average pattern unit
// ----------------------------------------------------------------------------
`default_nettype none
package nalbp_pkg;
   localparam int DefaultMaxWidth  = 1024;
   localparam int DefaultMaxHeight = 1024;
   localparam int DefaultNumScales = 3;
   localparam int Lines            = 6;
   localparam int Win              = 7;
   localparam int Bins             = 256;
   localparam logic [19:0] CountMax = 20'hFFFFF;
   localparam logic [10:0] SizeReset = 11'd512;

   localparam logic [1:0] OP_PIXEL      = 2'd0;
   localparam logic [1:0] OP_READ       = 2'd1;
   localparam logic [1:0] OP_READ_CLEAR = 2'd2;

   localparam logic [0:0] REG_WIDTH  = 1'b0;
   localparam logic [0:0] REG_HEIGHT = 1'b1;

   typedef struct packed {
      logic [1:0] opcode;
      logic [7:0] pixel_value;
      logic [1:0] hist_select;
      logic [7:0] bin_index;
   } req_type;

   typedef struct packed {
      logic [7:0]  code_one;
      logic        valid_one;
      logic [7:0]  code_two;
      logic        valid_two;
      logic [7:0]  code_three;
      logic        valid_three;
      logic [19:0] bin_count;
      logic        count_valid;
   } rsp_type;

   // classified command handed from front to back
   typedef struct packed {
      logic        is_pixel;
      logic        is_read;
      logic        is_clear;
      logic        sel_ok;
      logic [1:0]  hist_select;
      logic [7:0]  bin_index;
      logic [2:0]  code_valid;
      logic [23:0] codes;
   } cmd_type;

   function automatic logic [7:0] scale_code(input logic [7:0] ctr,
                                             input logic [63:0] nb);
      logic [11:0] sum;
      logic [12:0] num;
      logic [7:0]  avg;
      logic [7:0]  code;
      sum = {4'd0, ctr};
      for (int k = 0; k < 8; k++) sum = sum + {4'd0, nb[k*8 +: 8]};
      num = {sum, 1'b0} + 13'd9;
      avg = 8'((26'(num) * 26'd3641) >> 16);
      for (int k = 0; k < 8; k++) code[k] = (nb[k*8 +: 8] >= avg);
      return code;
   endfunction
endpackage
`default_nettype wire

// ===== rtl/nalbp_if.sv =====
// ----------------------------------------------------------------------------
// nalbp_if
// valid/ready channel carrying one payload beat
// ----------------------------------------------------------------------------
`default_nettype none
interface nalbp_if #(parameter type payload_type = logic);
   logic        valid;
   logic        ready;
   payload_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== rtl/nalbp_front.sv =====
// ----------------------------------------------------------------------------
// nalbp_front
// line stores, 7x7 window and pattern codes; emits classified commands
// ----------------------------------------------------------------------------
`default_nettype none
module nalbp_front #(
   parameter int MAX_WIDTH  = nalbp_pkg::DefaultMaxWidth,
   parameter int MAX_HEIGHT = nalbp_pkg::DefaultMaxHeight,
   parameter int NUM_SCALES = nalbp_pkg::DefaultNumScales
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic [10:0]       image_width,
   input  wire logic [10:0]       image_height,
   input  wire logic              in_valid,
   output logic                   in_ready,
   input  wire nalbp_pkg::req_type in_data,
   output logic                   out_valid,
   input  wire logic              out_ready,
   output nalbp_pkg::cmd_type     out_data
);
   localparam int CW = $clog2(MAX_WIDTH);
   localparam int RW = $clog2(MAX_HEIGHT);
   localparam int PW = (CW > RW ? CW : RW) + 1;

   logic [47:0] line_mem [MAX_WIDTH];
   logic [47:0] rd_ff;
   logic [7:0]  win_ff [7][7];
   logic        s1_valid_ff, s2_valid_ff;
   nalbp_pkg::req_type s1_req_ff;
   logic [2:0]  s1_ok_ff, s2_ok_ff;
   logic [CW-1:0] col_ff, col_in;
   logic [CW-1:0] s1_col_ff;
   logic [RW-1:0] row_ff, row_in;
   logic [CW-1:0] c_eff;
   logic [PW-1:0] w_eff, h_eff;
   logic        adv;
   logic        s2_pixel_ff;
   nalbp_pkg::req_type s2_req_ff;
   logic [7:0]  col [7];
   logic [47:0] wr_word;
   logic        s1_write;
   logic [2:0]  ok_now;
   nalbp_pkg::cmd_type cmd;

   always_comb begin
      if (image_width == 11'd0) w_eff = PW'(1);
      else if ({21'd0, image_width} > MAX_WIDTH) w_eff = PW'(MAX_WIDTH);
      else w_eff = PW'(image_width);
      if (image_height == 11'd0) h_eff = PW'(1);
      else if ({21'd0, image_height} > MAX_HEIGHT) h_eff = PW'(MAX_HEIGHT);
      else h_eff = PW'(image_height);
   end

   assign adv = out_ready || !s2_valid_ff;
   assign in_ready = adv;
   assign c_eff = col_ff;

   always_comb begin
      for (int s = 1; s <= 3; s++) begin
         ok_now[s-1] = (s <= NUM_SCALES) && (PW'(row_ff) >= PW'(2*s))
            && (PW'(col_ff) >= PW'(2*s)) && (PW'(row_ff) < h_eff)
            && (PW'(col_ff) < w_eff);
      end
      if (PW'(col_ff) + PW'(1) >= w_eff) begin
         col_in = '0;
         row_in = (PW'(row_ff) + PW'(1) >= h_eff) ? '0 : RW'(row_ff + 1'b1);
      end else begin
         col_in = CW'(col_ff + 1'b1);
         row_in = row_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
         s1_valid_ff <= 1'b0;
      end else if (adv) begin
         s1_valid_ff <= in_valid;
         if (in_valid && in_data.opcode == nalbp_pkg::OP_PIXEL) begin
            col_ff <= col_in;
            row_ff <= row_in;
         end
      end
   end

   // column entering the window: six stored rows then the new pixel
   always_comb begin
      for (int i = 0; i < 6; i++) col[i] = rd_ff[i*8 +: 8];
      col[6] = s1_req_ff.pixel_value;
   end

   assign wr_word  = {col[6], col[5], col[4], col[3], col[2], col[1]};
   assign s1_write = s1_valid_ff && s1_req_ff.opcode == nalbp_pkg::OP_PIXEL;

   always_ff @(posedge clock) begin
      if (adv && in_valid) begin
         s1_req_ff <= in_data;
         s1_ok_ff  <= ok_now;
         s1_col_ff <= c_eff;
         // same column written by the beat ahead
         if (s1_write && s1_col_ff == c_eff) rd_ff <= wr_word;
         else rd_ff <= line_mem[c_eff];
      end
   end

   always_ff @(posedge clock) begin
      if (adv && s1_write) begin
         line_mem[s1_col_ff] <= wr_word;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 7; i++)
            for (int j = 0; j < 7; j++) win_ff[i][j] <= '0;
         s2_valid_ff <= 1'b0;
      end else if (adv) begin
         s2_valid_ff <= s1_valid_ff;
         if (s1_valid_ff && s1_req_ff.opcode == nalbp_pkg::OP_PIXEL) begin
            for (int i = 0; i < 7; i++) begin
               for (int j = 0; j < 6; j++) win_ff[i][j] <= win_ff[i][j+1];
               win_ff[i][6] <= col[i];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv && s1_valid_ff) begin
         s2_req_ff   <= s1_req_ff;
         s2_ok_ff    <= s1_ok_ff;
         s2_pixel_ff <= s1_req_ff.opcode == nalbp_pkg::OP_PIXEL;
      end
   end

   always_comb begin
      cmd = '0;
      cmd.is_pixel    = s2_pixel_ff;
      cmd.is_read     = s2_req_ff.opcode == nalbp_pkg::OP_READ
         || s2_req_ff.opcode == nalbp_pkg::OP_READ_CLEAR;
      cmd.is_clear    = s2_req_ff.opcode == nalbp_pkg::OP_READ_CLEAR;
      cmd.sel_ok      = {30'd0, s2_req_ff.hist_select} < NUM_SCALES
         && s2_req_ff.hist_select != 2'd3;
      cmd.hist_select = s2_req_ff.hist_select;
      cmd.bin_index   = s2_req_ff.bin_index;
      if (s2_pixel_ff) begin
         for (int s = 1; s <= 3; s++) begin
            cmd.code_valid[s-1] = s2_ok_ff[s-1];
            if (s2_ok_ff[s-1])
               cmd.codes[(s-1)*8 +: 8] = nalbp_pkg::scale_code(
                  win_ff[6-s][6-s],
                  {win_ff[6-s][6-2*s], win_ff[6][6-2*s], win_ff[6][6-s],
                   win_ff[6][6], win_ff[6-s][6], win_ff[6-2*s][6],
                   win_ff[6-2*s][6-s], win_ff[6-2*s][6-2*s]});
         end
      end
   end

   assign out_valid = s2_valid_ff;
   assign out_data  = cmd;

   a_win_stall: assert property (@(posedge clock) disable iff (reset)
      out_valid && !out_ready |=> out_valid && $stable(s2_req_ff))
      else $error("front output changed under stall");
   a_no_code_on_read: assert property (@(posedge clock) disable iff (reset)
      out_valid && !cmd.is_pixel |-> cmd.code_valid == 3'd0)
      else $error("code valid on non-pixel command");
   a_pos_hold: assert property (@(posedge clock) disable iff (reset)
      !adv |=> $stable(col_ff) && $stable(row_ff))
      else $error("position moved during stall");
endmodule
`default_nettype wire

// ===== rtl/nalbp_back.sv =====
// ----------------------------------------------------------------------------
// nalbp_back
// histogram memories with read/clear and saturating increments
// ----------------------------------------------------------------------------
`default_nettype none
module nalbp_back #(
   parameter int NUM_SCALES = nalbp_pkg::DefaultNumScales
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               in_valid,
   output logic                    in_ready,
   input  wire nalbp_pkg::cmd_type in_data,
   output logic                    out_valid,
   input  wire logic               out_ready,
   output nalbp_pkg::rsp_type      out_data
);
   // three banks, each read/modify/write one bin per beat
   logic [19:0] hist_mem [3][256];
   logic        clr_busy_ff;
   logic [7:0]  clr_addr_ff;
   logic        take;
   logic        q_valid_ff;
   nalbp_pkg::cmd_type q_ff;
   logic [19:0] rd_ff [3];
   logic        o_valid_ff;
   nalbp_pkg::rsp_type o_ff;
   logic        adv;
   logic [7:0]  addr [3];
   logic [19:0] cur [3];
   logic [2:0]  hit;
   nalbp_pkg::rsp_type rsp;

   assign adv = out_ready || !o_valid_ff;
   assign in_ready = adv && !clr_busy_ff;
   assign take = in_valid && !clr_busy_ff;

   always_comb begin
      for (int b = 0; b < 3; b++) begin
         addr[b] = in_data.is_pixel ? in_data.codes[b*8 +: 8] : in_data.bin_index;
         // forward the bin written last beat
         hit[b] = q_valid_ff && (q_ff.is_pixel ? q_ff.code_valid[b]
            : (q_ff.is_clear && q_ff.sel_ok && q_ff.hist_select == 2'(b)))
            && (q_ff.is_pixel ? q_ff.codes[b*8 +: 8] : q_ff.bin_index)
            == addr[b];
      end
   end

   logic [19:0] nxt [3];
   logic [2:0]  wr;
   always_comb begin
      for (int b = 0; b < 3; b++) begin
         cur[b] = rd_ff[b];
         wr[b]  = 1'b0;
         nxt[b] = cur[b];
         if (q_valid_ff) begin
            if (q_ff.is_pixel && q_ff.code_valid[b]) begin
               wr[b]  = 1'b1;
               nxt[b] = (cur[b] == nalbp_pkg::CountMax) ? cur[b] : cur[b] + 20'd1;
            end else if (q_ff.is_clear && q_ff.sel_ok && q_ff.hist_select == 2'(b)) begin
               wr[b]  = 1'b1;
               nxt[b] = '0;
            end
         end
      end
      rsp = '0;
      if (q_ff.is_pixel) begin
         rsp.code_one    = q_ff.codes[7:0];
         rsp.valid_one   = q_ff.code_valid[0];
         rsp.code_two    = q_ff.codes[15:8];
         rsp.valid_two   = q_ff.code_valid[1];
         rsp.code_three  = q_ff.codes[23:16];
         rsp.valid_three = q_ff.code_valid[2];
      end else if (q_ff.is_read) begin
         rsp.count_valid = 1'b1;
         rsp.bin_count   = q_ff.sel_ok ? cur[q_ff.hist_select] : 20'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         q_valid_ff  <= 1'b0;
         o_valid_ff  <= 1'b0;
         clr_busy_ff <= 1'b1;
         clr_addr_ff <= '0;
      end else begin
         // clearing pass over all bins after reset
         if (clr_busy_ff) begin
            clr_addr_ff <= clr_addr_ff + 8'd1;
            if (clr_addr_ff == 8'hFF) clr_busy_ff <= 1'b0;
         end
         if (adv) begin
            q_valid_ff <= take;
            o_valid_ff <= q_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (clr_busy_ff) begin
         for (int b = 0; b < 3; b++) hist_mem[b][clr_addr_ff] <= '0;
      end else if (adv) begin
         o_ff <= rsp;
         if (take) q_ff <= in_data;
         for (int b = 0; b < 3; b++) begin
            if (q_valid_ff && wr[b])
               hist_mem[b][q_ff.is_pixel ? q_ff.codes[b*8 +: 8] : q_ff.bin_index] <= nxt[b];
            if (take) begin
               if (hit[b] && wr[b]) rd_ff[b] <= nxt[b];
               else rd_ff[b] <= hist_mem[b][addr[b]];
            end
         end
      end
   end

   assign out_valid = o_valid_ff;
   assign out_data  = o_ff;

   a_single_kind: assert property (@(posedge clock) disable iff (reset)
      out_valid |-> !(out_data.count_valid && (out_data.valid_one
         || out_data.valid_two || out_data.valid_three)))
      else $error("read and code in one beat");
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      out_valid && !out_ready |=> $stable(out_data))
      else $error("result changed under stall");
   a_bad_sel_zero: assert property (@(posedge clock) disable iff (reset)
      q_valid_ff && q_ff.is_read && !q_ff.sel_ok && adv |=> o_ff.bin_count == 20'd0)
      else $error("unused histogram read nonzero");
endmodule
`default_nettype wire

// ===== rtl/neighbor_average_lbp_three_scales_unit.sv =====
// ----------------------------------------------------------------------------
// neighbor_average_lbp_three_scales_unit
// three-scale neighbor-average pattern codes with per-scale histograms
// ----------------------------------------------------------------------------
// req channel: one beat per pixel (opcode 0) or histogram read (1, 2).
// rsp channel: exactly one beat per req beat, in order. pixel beats carry
// the three scale codes with their valid bits; read beats carry bin_count.
// from req acceptance to rsp valid a beat passes two front stages (line
// store read, window and code), one back stage (bin read) and the output
// register, which also takes the bin update. one beat is taken every
// cycle while rsp is not stalled and no bin clearing runs; line store and
// histogram updates forward across back-to-back beats.
// csr port: image_width at 0, image_height at 4; write only while idle.
// reset clears position, window and all pipeline valids; sizes return to
// 512. the histogram banks are then cleared over all 256 bins, during which
// the back stage takes nothing. when rsp stalls, the back stages hold and
// req_ready drops once the front's window stage holds a beat.
// ----------------------------------------------------------------------------
`default_nettype none
module neighbor_average_lbp_three_scales_unit #(
   parameter int MAX_WIDTH  = nalbp_pkg::DefaultMaxWidth,
   parameter int MAX_HEIGHT = nalbp_pkg::DefaultMaxHeight,
   parameter int NUM_SCALES = nalbp_pkg::DefaultNumScales
) (
   input  wire logic        clock,
   input  wire logic        reset,
   nalbp_if.sink            req,
   nalbp_if.source          rsp,
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [2:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic [31:0]      csr_prdata,
   output logic             csr_pready
);
   logic [10:0] width_ff, height_ff;
   logic        mid_valid, mid_ready;
   nalbp_pkg::cmd_type mid_data;

   assign csr_pready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= nalbp_pkg::SizeReset;
         height_ff <= nalbp_pkg::SizeReset;
      end else if (csr_psel && csr_penable && csr_pwrite) begin
         if (csr_paddr[1:0] == 2'd0 && csr_paddr[2] == nalbp_pkg::REG_WIDTH)
            width_ff <= csr_pwdata[10:0];
         if (csr_paddr[1:0] == 2'd0 && csr_paddr[2] == nalbp_pkg::REG_HEIGHT)
            height_ff <= csr_pwdata[10:0];
      end
   end
   always_comb begin
      csr_prdata = '0;
      if (csr_paddr[2] == nalbp_pkg::REG_WIDTH) csr_prdata = {21'd0, width_ff};
      else csr_prdata = {21'd0, height_ff};
   end

   nalbp_front #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT),
      .NUM_SCALES(NUM_SCALES)) u_front (
      .clock, .reset, .image_width(width_ff), .image_height(height_ff),
      .in_valid(req.valid), .in_ready(req.ready), .in_data(req.data),
      .out_valid(mid_valid), .out_ready(mid_ready), .out_data(mid_data));

   nalbp_back #(.NUM_SCALES(NUM_SCALES)) u_back (
      .clock, .reset, .in_valid(mid_valid), .in_ready(mid_ready),
      .in_data(mid_data), .out_valid(rsp.valid), .out_ready(rsp.ready),
      .out_data(rsp.data));
endmodule
`default_nettype wire
